// ===== rtl/cht_pkg.sv =====
package cht_pkg;

  localparam int TABLE_SIZE = 1024;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int KICK_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int TDATA_W    = 64;

  localparam logic [KICK_W-1:0] KICK_RESET = 8'd50;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_PLACED    = 3'd0,
    STATUS_UPDATED   = 3'd1,
    STATUS_REMOVED   = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_DROPPED   = 3'd4
  } status_t;

  // One slot of a table: the valid flag stands in the top bit.
  typedef struct packed {
    logic valid;
    key_t key;
    val_t value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Request from the sequencer to one table memory.
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    logic   re;
    idx_t   raddr;
  } ram_req_t;

  // TABLE_SIZE is a power of two, so these reduce to bit slices.
  function automatic idx_t slot_one(key_t k);
    slot_one = idx_t'(k % TABLE_SIZE);
  endfunction

  function automatic idx_t slot_two(key_t k);
    slot_two = idx_t'((k / TABLE_SIZE) % TABLE_SIZE);
  endfunction

endpackage

// ===== rtl/cht_ram.sv =====
module cht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cht_ctrl.sv =====
module cht_ctrl import cht_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                in_action,
  input  key_t                in_key,
  input  val_t                in_value,
  input  logic [KICK_W-1:0]   max_kick_rounds,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [STATUS_W-1:0] m_tuser,
  output logic [TDATA_W-1:0]  m_tdata,
  output ram_req_t            req_one,
  output ram_req_t            req_two,
  input  entry_t              rd_one,
  input  entry_t              rd_two
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE1,
    ST_PROBE2,
    ST_REMOVE,
    ST_FINISH
  } state_t;

  state_t              state;
  idx_t                clr_idx;
  key_t                hand_key;
  val_t                hand_val;
  logic [KICK_W-1:0]   round;
  status_t             res_status;
  key_t                res_key;
  val_t                res_val;

  logic hit_one;
  logic hit_two;
  logic last_round;

  assign hit_one    = rd_one.valid && (rd_one.key == hand_key);
  assign hit_two    = rd_two.valid && (rd_two.key == hand_key);
  assign last_round = (KICK_W'(round + 1'b1) == max_kick_rounds);
  assign s_tready   = (state == ST_IDLE);

  always_comb begin
    req_one = '0;
    req_two = '0;
    unique case (state)
      ST_CLEAR: begin
        req_one.we    = 1'b1;
        req_one.waddr = clr_idx;
        req_two.we    = 1'b1;
        req_two.waddr = clr_idx;
      end
      ST_IDLE: begin
        req_one.re    = s_tvalid;
        req_one.raddr = slot_one(in_key);
        req_two.re    = s_tvalid;
        req_two.raddr = slot_two(in_key);
      end
      ST_PROBE1: begin
        // The pair in hand always lands in table one; an occupant with
        // another key is carried on to its slot in table two.
        req_one.we    = 1'b1;
        req_one.waddr = slot_one(hand_key);
        req_one.wdata = '{valid: 1'b1, key: hand_key, value: hand_val};
        req_two.re    = rd_one.valid && !hit_one;
        req_two.raddr = slot_two(rd_one.key);
      end
      ST_PROBE2: begin
        req_two.we    = 1'b1;
        req_two.waddr = slot_two(hand_key);
        req_two.wdata = '{valid: 1'b1, key: hand_key, value: hand_val};
        req_one.re    = rd_two.valid && !hit_two && !last_round;
        req_one.raddr = slot_one(rd_two.key);
      end
      ST_REMOVE: begin
        if (hit_one) begin
          req_one.we    = 1'b1;
          req_one.waddr = slot_one(hand_key);
          req_one.wdata = '{valid: 1'b0, key: rd_one.key, value: rd_one.value};
        end else if (hit_two) begin
          req_two.we    = 1'b1;
          req_two.waddr = slot_two(hand_key);
          req_two.wdata = '{valid: 1'b0, key: rd_two.key, value: rd_two.value};
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      round    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= idx_t'(clr_idx + 1'b1);
          if (clr_idx == idx_t'(TABLE_SIZE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            hand_key <= in_key;
            hand_val <= in_value;
            round    <= '0;
            res_key  <= '0;
            res_val  <= '0;
            if (in_action == ACT_REMOVE) begin
              state <= ST_REMOVE;
            end else if (max_kick_rounds == '0) begin
              res_status <= STATUS_DROPPED;
              res_key    <= in_key;
              res_val    <= in_value;
              state      <= ST_FINISH;
            end else begin
              state <= ST_PROBE1;
            end
          end
        end
        ST_PROBE1: begin
          if (!rd_one.valid || hit_one) begin
            res_status <= (round == '0 && hit_one) ? STATUS_UPDATED : STATUS_PLACED;
            state      <= ST_FINISH;
          end else begin
            hand_key <= rd_one.key;
            hand_val <= rd_one.value;
            state    <= ST_PROBE2;
          end
        end
        ST_PROBE2: begin
          if (!rd_two.valid || hit_two) begin
            res_status <= STATUS_PLACED;
            state      <= ST_FINISH;
          end else if (last_round) begin
            res_status <= STATUS_DROPPED;
            res_key    <= rd_two.key;
            res_val    <= rd_two.value;
            state      <= ST_FINISH;
          end else begin
            hand_key <= rd_two.key;
            hand_val <= rd_two.value;
            round    <= KICK_W'(round + 1'b1);
            state    <= ST_PROBE1;
          end
        end
        ST_REMOVE: begin
          res_status <= (hit_one || hit_two) ? STATUS_REMOVED : STATUS_NOT_FOUND;
          state      <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {1'b0, res_val, res_key};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/cuckoo_hash_table.sv =====
// Flow: an accepted item reads both tables; an insert then writes table one and table two in
// turn, carrying each displaced pair on, until it settles or max_kick_rounds is used up, and a
// remove clears a matching slot. The result is presented from a finish state that waits while
// the output is stalled; no new item is taken until the last result is in the output register.
// Reset (rst, synchronous) clears the control state, sets max_kick_rounds to 50 and then
// sweeps every slot of both tables empty, during which no input is taken.
module cuckoo_hash_table import cht_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [TDATA_W-1:0]  s_tdata,   // key [30:0], value [62:31], zero [63]
  input  logic                s_tuser,   // action [0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [TDATA_W-1:0]  m_tdata,   // dropped_key [30:0], dropped_value [62:31], zero [63]
  output logic [STATUS_W-1:0] m_tuser,   // status [2:0]
  input  logic                cfg_wr_en,
  input  logic [KICK_W-1:0]   cfg_wr_data
);

  logic [KICK_W-1:0] max_kick_rounds;
  ram_req_t          req_one;
  ram_req_t          req_two;
  entry_t            rd_one;
  entry_t            rd_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_kick_rounds <= KICK_RESET;
    end else if (cfg_wr_en) begin
      max_kick_rounds <= cfg_wr_data;
    end
  end

  cht_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .in_action       (s_tuser),
    .in_key          (s_tdata[KEY_W-1:0]),
    .in_value        (s_tdata[KEY_W+VAL_W-1:KEY_W]),
    .max_kick_rounds (max_kick_rounds),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tuser         (m_tuser),
    .m_tdata         (m_tdata),
    .req_one         (req_one),
    .req_two         (req_two),
    .rd_one          (rd_one),
    .rd_two          (rd_two)
  );

  cht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_table_one (
    .clk   (clk),
    .we    (req_one.we),
    .waddr (req_one.waddr),
    .wdata (req_one.wdata),
    .re    (req_one.re),
    .raddr (req_one.raddr),
    .rdata (rd_one)
  );

  cht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_table_two (
    .clk   (clk),
    .we    (req_two.we),
    .waddr (req_two.waddr),
    .wdata (req_two.wdata),
    .re    (req_two.re),
    .raddr (req_two.raddr),
    .rdata (rd_two)
  );

`ifndef ASSERT_OFF
  // Only one item is in work: an accepted transfer closes the input for the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  // The dropped pair fields are zero unless a pair was dropped.
  a_drop_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != STATUS_DROPPED)) |-> (m_tdata == '0))
    else $error("dropped pair reported without a drop status");

  // A result never appears in the cycle right after an input transfer.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
    else $error("result presented before the tables were probed");
`endif

endmodule

// ===== test/cuckoo_hash_table_checker.sv =====
`timescale 1ns / 1ps

module cuckoo_hash_table_checker import cht_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [TDATA_W-1:0]  s_tdata,
  input  logic                s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [TDATA_W-1:0]  m_tdata,
  input  logic [STATUS_W-1:0] m_tuser,
  input  logic                cfg_wr_en,
  input  logic [KICK_W-1:0]   cfg_wr_data,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen,
  output int                  drops_seen
);

  typedef struct packed {
    status_t status;
    key_t    drop_key;
    val_t    drop_value;
  } reply_t;

  key_t  t1_key   [TABLE_SIZE];
  val_t  t1_value [TABLE_SIZE];
  bit    t1_valid [TABLE_SIZE];
  key_t  t2_key   [TABLE_SIZE];
  val_t  t2_value [TABLE_SIZE];
  bit    t2_valid [TABLE_SIZE];
  logic [KICK_W-1:0] kick_limit;

  reply_t expected_replies[$];

  // Table one is addressed by the low key bits, table two by the next group up.
  function automatic idx_t row_one(key_t k);
    return k[IDX_W-1:0];
  endfunction

  function automatic idx_t row_two(key_t k);
    return idx_t'(k >> IDX_W);
  endfunction

  // Applies one operation to the shadow tables and returns the reply it should produce.
  function automatic reply_t run_table_op(logic act, key_t k, val_t v);
    reply_t r;
    key_t   hand_key;
    val_t   hand_value;
    key_t   tk;
    val_t   tv;
    idx_t   p1;
    idx_t   p2;
    bit     settled;
    r = '{STATUS_PLACED, '0, '0};
    if (act == ACT_REMOVE) begin
      p1 = row_one(k);
      p2 = row_two(k);
      if (t1_valid[p1] && t1_key[p1] == k) begin
        t1_valid[p1] = 1'b0;
        r.status = STATUS_REMOVED;
      end else if (t2_valid[p2] && t2_key[p2] == k) begin
        t2_valid[p2] = 1'b0;
        r.status = STATUS_REMOVED;
      end else begin
        r.status = STATUS_NOT_FOUND;
      end
    end else begin
      hand_key   = k;
      hand_value = v;
      settled    = 1'b0;
      for (int round = 0; round < kick_limit && !settled; round++) begin
        p1 = row_one(hand_key);
        if (!t1_valid[p1] || t1_key[p1] == hand_key) begin
          // Only a match on the very first probe counts as an update.
          if (round == 0 && t1_valid[p1]) r.status = STATUS_UPDATED;
          t1_key[p1]   = hand_key;
          t1_value[p1] = hand_value;
          t1_valid[p1] = 1'b1;
          settled      = 1'b1;
        end else begin
          tk = t1_key[p1];
          tv = t1_value[p1];
          t1_key[p1]   = hand_key;
          t1_value[p1] = hand_value;
          hand_key     = tk;
          hand_value   = tv;
          p2 = row_two(hand_key);
          if (!t2_valid[p2] || t2_key[p2] == hand_key) begin
            t2_key[p2]   = hand_key;
            t2_value[p2] = hand_value;
            t2_valid[p2] = 1'b1;
            settled      = 1'b1;
          end else begin
            tk = t2_key[p2];
            tv = t2_value[p2];
            t2_key[p2]   = hand_key;
            t2_value[p2] = hand_value;
            hand_key     = tk;
            hand_value   = tv;
          end
        end
      end
      if (!settled) begin
        r.status     = STATUS_DROPPED;
        r.drop_key   = hand_key;
        r.drop_value = hand_value;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: %s: got %0h, expected %0h (result %0d)",
             $realtime, what, got, want, results_seen);
    fail_count++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        t1_valid[i] = 1'b0;
        t2_valid[i] = 1'b0;
      end
      kick_limit = KICK_RESET;
      expected_replies.delete();
      fail_count   = 0;
      results_seen = 0;
      drops_seen   = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result transfer with nothing pending", m_tdata, '0);
        end else begin
          want = expected_replies.pop_front();
          if (m_tuser != want.status)
            report_mismatch("status", 64'(m_tuser), 64'(want.status));
          if (m_tdata[KEY_W-1:0] != want.drop_key)
            report_mismatch("dropped_key", 64'(m_tdata[KEY_W-1:0]), 64'(want.drop_key));
          if (m_tdata[KEY_W+VAL_W-1:KEY_W] != want.drop_value)
            report_mismatch("dropped_value", 64'(m_tdata[KEY_W+VAL_W-1:KEY_W]),
                            64'(want.drop_value));
          if (m_tdata[TDATA_W-1] != 1'b0)
            report_mismatch("tdata pad bit", 64'(m_tdata[TDATA_W-1]), 64'(1'b0));
        end
        results_seen++;
        if (m_tuser == STATUS_DROPPED) drops_seen++;
      end
      if (s_tvalid && s_tready)
        expected_replies.insert(expected_replies.size(),
                                run_table_op(s_tuser, s_tdata[KEY_W-1:0],
                                             s_tdata[KEY_W+VAL_W-1:KEY_W]));
      if (cfg_wr_en) kick_limit = cfg_wr_data;
    end
    pending = expected_replies.size();
  end

endmodule

// ===== test/cuckoo_hash_table_tb.sv =====
`timescale 1ns / 1ps

module cuckoo_hash_table_tb;
  import cht_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata;   // key [30:0], value [62:31], zero [63]
  logic                s_tuser;   // action [0]
  logic                m_tvalid;
  logic                m_tready;
  logic [TDATA_W-1:0]  m_tdata;   // dropped_key [30:0], dropped_value [62:31], zero [63]
  logic [STATUS_W-1:0] m_tuser;   // status [2:0]
  logic                cfg_wr_en;
  logic [KICK_W-1:0]   cfg_wr_data;

  int fail_count;
  int pending;
  int results_seen;
  int drops_seen;
  int cycle_count;
  int ops_sent;
  int settings_used;
  int stall_left;
  bit gaps_on;
  bit stalls_on;

  cuckoo_hash_table dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  cuckoo_hash_table_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen),
    .drops_seen  (drops_seen)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: mostly ready, short stalls now and then, and an occasional long one.
  always @(negedge clk) begin
    int r;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!stalls_on) begin
      m_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_tready <= 1'b1;
      end else if (r < 96) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  // Drives one operation, holds it until the transfer, then maybe leaves a gap.
  task automatic issue(input logic act, input key_t k, input val_t v);
    int r;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, v, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    ops_sent++;
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(10, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Holds off the sender until every pending result has been delivered.
  task automatic drain();
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_kick_limit(input logic [KICK_W-1:0] rounds);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rounds;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  // Most keys come from a narrow pool so both tables collide heavily; the rest are
  // unconstrained so every key bit toggles.
  function automatic key_t pick_key();
    int r;
    logic [10:0] hi;
    logic [9:0]  mid;
    logic [9:0]  lo;
    r = $urandom_range(0, 9);
    if (r < 2) return key_t'($urandom());
    if (r < 5) hi = '0;
    else if (r < 8) hi = 11'($urandom_range(0, 3));
    else hi = 11'($urandom());
    mid = 10'($urandom_range(0, 15));
    lo  = 10'($urandom_range(0, 15));
    return {hi, mid, lo};
  endfunction

  task automatic random_ops(input int count, input int remove_pct);
    logic act;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(0, 99) < remove_pct) ? ACT_REMOVE : ACT_INSERT;
      issue(act, pick_key(), val_t'($urandom()));
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = ACT_INSERT;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    ops_sent      = 0;
    settings_used = 1;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed checks under the reset kick limit.
    issue(ACT_INSERT, 31'd0, 32'h8000_0000);
    issue(ACT_INSERT, 31'd0, 32'h7FFF_FFFF);
    issue(ACT_INSERT, 31'h7FFF_FFFF, 32'h0000_0000);
    issue(ACT_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    issue(ACT_REMOVE, 31'h7FFF_FFFF, 32'h0000_0000);
    issue(ACT_REMOVE, 31'h7FFF_FFFF, 32'h0000_0000);
    issue(ACT_REMOVE, 31'd0, 32'hDEAD_BEEF);
    // Two keys sharing a table-one slot push the first into table two; reinserting
    // it then leaves a second copy in table one.
    issue(ACT_INSERT, 31'd5, 32'h0000_00A5);
    issue(ACT_INSERT, 31'd1029, 32'h0000_0B29);
    issue(ACT_INSERT, 31'd5, 32'h0000_0C05);
    issue(ACT_REMOVE, 31'd5, 32'h0);
    issue(ACT_REMOVE, 31'd5, 32'h0);
    issue(ACT_REMOVE, 31'd5, 32'h0);
    issue(ACT_REMOVE, 31'd1029, 32'h0);
    issue(ACT_INSERT, 31'h5555_5555, 32'hAAAA_AAAA);
    issue(ACT_INSERT, 31'h2AAA_AAAA, 32'h5555_5555);
    issue(ACT_INSERT, 31'h7FF0_0000, 32'h1234_5678);
    issue(ACT_INSERT, 31'h000F_FC00, 32'h8765_4321);
    issue(ACT_REMOVE, 31'h2AAA_AAAA, 32'h0);

    random_ops(60, 35);
    drain();
    random_ops(40, 35);

    write_kick_limit(8'd1);
    random_ops(90, 35);

    write_kick_limit(8'd255);
    random_ops(50, 30);

    // With no rounds allowed every insert hands its own pair back.
    write_kick_limit(8'd0);
    issue(ACT_INSERT, 31'h0001_2345, 32'hFFFF_0000);
    issue(ACT_REMOVE, 31'h0001_2345, 32'h0);
    issue(ACT_INSERT, 31'h5555_5555, 32'h0F0F_0F0F);
    random_ops(30, 40);

    write_kick_limit(8'd3);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_ops(80, 35);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    random_ops(80, 35);

    write_kick_limit(KICK_W'($urandom_range(2, 20)));
    random_ops(100, 35);

    write_kick_limit(8'd50);
    random_ops(80, 35);

    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d insert/remove operations over %0d kick-limit settings (0 and 255 included).",
             ops_sent, settings_used);
    $display("Checked %0d results; %0d of them reported a dropped pair.",
             results_seen, drops_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
